FILE: sv/tmse_pkg.sv
// ----------------------------------------------------------------------------
// tmse_pkg
// Shared types and codes of the Turing machine step engine: request and
// response payloads, operation and status codes, sequencer phases.
// ----------------------------------------------------------------------------
`default_nettype none

package tmse_pkg;

    typedef enum logic [2:0] {
        OP_WRITE_RULE = 3'd0,
        OP_WRITE_CELL = 3'd1,
        OP_START      = 3'd2,
        OP_STEP       = 3'd3,
        OP_READ_CELL  = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_RUN     = 3'd1,
        ST_ACCEPT  = 3'd2,
        ST_REJECT  = 3'd3,
        ST_EDGE    = 3'd4,
        ST_NO_RULE = 3'd5
    } t_status;

    localparam logic [1:0] MV_LEFT  = 2'd0;
    localparam logic [1:0] MV_RIGHT = 2'd1;
    localparam logic [1:0] MV_STAY  = 2'd2;

    localparam logic [2:0] CFG_START_STATE  = 3'd0;
    localparam logic [2:0] CFG_HALT_STATE   = 3'd1;
    localparam logic [2:0] CFG_REJECT_STATE = 3'd2;
    localparam logic [2:0] CFG_START_HEAD   = 3'd3;
    localparam logic [2:0] CFG_BLANK_SYMBOL = 3'd4;

    localparam logic [7:0] BLANK_RESET = 8'd66;

    typedef struct packed {
        logic [2:0] operation;
        logic [4:0] rule_state;
        logic [7:0] rule_symbol;
        logic [4:0] next_state;
        logic [7:0] write_symbol;
        logic [1:0] move;
        logic [9:0] tape_address;
        logic [7:0] tape_symbol;
    } t_req;

    typedef struct packed {
        t_status    status;
        logic [4:0] current_state;
        logic [9:0] head_position;
        logic [7:0] read_symbol;
    } t_rsp;

    typedef enum logic [1:0] {
        PH_CLEAR = 2'd0,
        PH_IDLE  = 2'd1,
        PH_RULE  = 2'd2,
        PH_EXEC  = 2'd3
    } t_phase;

    typedef struct packed {
        logic clearing;
        logic idle;
        logic rule_rd;
        logic exec;
        logic clr_last;
    } t_seq_ctl;

endpackage

`default_nettype wire

FILE: sv/tmse_ram.sv
// ----------------------------------------------------------------------------
// tmse_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tmse_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold read data between reads
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: sv/tmse_seq.sv
// ----------------------------------------------------------------------------
// tmse_seq
// Phase sequencer: clearing pass after reset, then accept, rule read and
// execute phases for one request at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module tmse_seq
    import tmse_pkg::*;
#(
    parameter int CLR_DEPTH = 8192,
    parameter int CLR_W     = $clog2(CLR_DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_req_fire,
    input  wire logic             i_advance,
    output t_seq_ctl              o_ctl,
    output logic      [CLR_W-1:0] o_clr_addr
);

    t_phase           r_phase, n_phase;
    logic [CLR_W-1:0] r_clr, n_clr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_CLEAR;
            r_clr   <= '0;
        end else begin
            r_phase <= n_phase;
            r_clr   <= n_clr;
        end
    end

    always_comb begin
        n_phase        = r_phase;
        n_clr          = r_clr;
        o_ctl          = '0;
        o_ctl.clr_last = (r_clr == CLR_W'(CLR_DEPTH - 1));
        case (r_phase)
            PH_CLEAR: begin
                o_ctl.clearing = 1'b1;
                n_clr          = r_clr + CLR_W'(1);
                if (o_ctl.clr_last) begin
                    n_phase = PH_IDLE;
                end
            end
            PH_IDLE: begin
                o_ctl.idle = 1'b1;
                if (i_req_fire) begin
                    n_phase = PH_RULE;
                end
            end
            PH_RULE: begin
                o_ctl.rule_rd = 1'b1;
                n_phase       = PH_EXEC;
            end
            PH_EXEC: begin
                o_ctl.exec = 1'b1;
                if (i_advance) begin
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    assign o_clr_addr = r_clr;

endmodule

`default_nettype wire

FILE: sv/turing_machine_step_engine.sv
// ----------------------------------------------------------------------------
// turing_machine_step_engine
// Single-tape Turing machine engine with a bounded tape. Rules and tape cells
// live in synchronous RAMs; a sequencer reads the tape, then the rule that
// the symbol selects, then writes back tape, head and state.
// ----------------------------------------------------------------------------
//
//  channel   | direction | handshake                  | payload
//  ----------+-----------+----------------------------+---------------
//  request   | in        | i_req_valid / o_req_stall  | i_req (t_req)
//  response  | out       | o_rsp_valid / i_rsp_stall  | o_rsp (t_rsp)
//  config    | in        | i_cfg_we (no wait)         | i_cfg_index, i_cfg_data
//
//  Phases per request: the accept phase issues the tape read, the rule read
//  phase issues the rule read addressed by the symbol read, the execute phase
//  executes and writes back. The chain tape RAM -> rule RAM -> tape write sets this.
//  Reset: a clearing pass over every rule and tape address invalidates every
//  rule and blanks the tape; requests are stalled meanwhile, configuration
//  writes are taken.
//  Stalls: the response register parts the two sides; the execute phase
//  holds while a previous response is still waiting.
// ----------------------------------------------------------------------------
`default_nettype none

module turing_machine_step_engine
    import tmse_pkg::*;
#(
    parameter int NUM_STATES  = 32,
    parameter int TAPE_LEN    = 1024,
    parameter int SYMBOL_BITS = 8
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // request channel
    input  wire logic       i_req_valid,
    output logic            o_req_stall,
    input  wire t_req       i_req,
    // response channel
    output logic            o_rsp_valid,
    input  wire logic       i_rsp_stall,
    output t_rsp            o_rsp,
    // configuration write port
    input  wire logic       i_cfg_we,
    input  wire logic [2:0] i_cfg_index,
    input  wire logic [9:0] i_cfg_data
);

    // ------------------------------------------------------------------
    // Derived sizes
    // ------------------------------------------------------------------
    localparam int SYM_COUNT  = 1 << SYMBOL_BITS;
    localparam int RULE_DEPTH = NUM_STATES * SYM_COUNT;
    localparam int SIDX_W     = $clog2(NUM_STATES);
    localparam int RA_W       = SIDX_W + SYMBOL_BITS;
    localparam int TA_W       = $clog2(TAPE_LEN);
    // rule word: valid, next state, written symbol, move
    localparam int RULE_W     = 1 + 5 + SYMBOL_BITS + 2;
    localparam int CLR_DEPTH  = (RULE_DEPTH > TAPE_LEN) ? RULE_DEPTH : TAPE_LEN;
    localparam int CLR_W      = $clog2(CLR_DEPTH);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [4:0]             r_start_state;
    logic [4:0]             r_halt_state;
    logic [4:0]             r_reject_state;
    logic [9:0]             r_start_head;
    logic [SYMBOL_BITS-1:0] r_blank;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_state  <= 5'd0;
            r_halt_state   <= 5'd1;
            r_reject_state <= 5'd2;
            r_start_head   <= 10'd0;
            r_blank        <= SYMBOL_BITS'(BLANK_RESET);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_START_STATE:  r_start_state  <= i_cfg_data[4:0];
                CFG_HALT_STATE:   r_halt_state   <= i_cfg_data[4:0];
                CFG_REJECT_STATE: r_reject_state <= i_cfg_data[4:0];
                CFG_START_HEAD:   r_start_head   <= i_cfg_data;
                CFG_BLANK_SYMBOL: r_blank        <= i_cfg_data[SYMBOL_BITS-1:0];
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    t_seq_ctl         ctl;
    logic [CLR_W-1:0] clr_addr;
    logic             req_fire;
    logic             advance;

    assign o_req_stall = !ctl.idle;
    assign req_fire    = i_req_valid && !o_req_stall;
    // the execute phase may finish only when the response slot is free
    assign advance     = !o_rsp_valid || !i_rsp_stall;

    tmse_seq #(
        .CLR_DEPTH (CLR_DEPTH)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_fire (req_fire),
        .i_advance  (advance),
        .o_ctl      (ctl),
        .o_clr_addr (clr_addr)
    );

    // ------------------------------------------------------------------
    // Machine registers and latched request
    // ------------------------------------------------------------------
    t_req        r_req;
    t_status     r_status, n_status;
    logic [4:0]  r_mstate, n_mstate;
    logic [TA_W-1:0] r_head, n_head;

    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_req <= i_req;
        end
    end

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    logic                   tape_we, tape_re;
    logic [TA_W-1:0]        tape_waddr, tape_raddr;
    logic [SYMBOL_BITS-1:0] tape_wdata, tape_q;

    logic                   rule_we, rule_re;
    logic [RA_W-1:0]        rule_waddr, rule_raddr;
    logic [RULE_W-1:0]      rule_wdata, rule_q;

    tmse_ram #(
        .WIDTH  (SYMBOL_BITS),
        .DEPTH  (TAPE_LEN),
        .ADDR_W (TA_W)
    ) u_tape_ram (
        .i_clk   (i_clk),
        .i_we    (tape_we),
        .i_waddr (tape_waddr),
        .i_wdata (tape_wdata),
        .i_re    (tape_re),
        .i_raddr (tape_raddr),
        .o_rdata (tape_q)
    );

    tmse_ram #(
        .WIDTH  (RULE_W),
        .DEPTH  (RULE_DEPTH),
        .ADDR_W (RA_W)
    ) u_rule_ram (
        .i_clk   (i_clk),
        .i_we    (rule_we),
        .i_waddr (rule_waddr),
        .i_wdata (rule_wdata),
        .i_re    (rule_re),
        .i_raddr (rule_raddr),
        .o_rdata (rule_q)
    );

    // Tape read at accept: the addressed cell for a cell read, the cell under
    // the head otherwise. The serial phases put any write-back ahead of the next
    // read, so no forwarding is needed.
    assign tape_re    = req_fire;
    assign tape_raddr = (i_req.operation == OP_READ_CELL)
                        ? TA_W'(i_req.tape_address) : r_head;

    // Rule read keyed by current state and the symbol just read
    logic [7:0] mstate_ext;
    assign mstate_ext = 8'(r_mstate);
    assign rule_re    = ctl.rule_rd;
    assign rule_raddr = {mstate_ext[SIDX_W-1:0], tape_q};

    // Rule word fields
    logic                   rq_valid;
    logic [4:0]             rq_next;
    logic [SYMBOL_BITS-1:0] rq_sym;
    logic [1:0]             rq_move;

    assign rq_valid = rule_q[RULE_W-1];
    assign rq_next  = rule_q[RULE_W-2 -: 5];
    assign rq_sym   = rule_q[SYMBOL_BITS+1:2];
    assign rq_move  = rule_q[1:0];

    // ------------------------------------------------------------------
    // Execute phase
    // ------------------------------------------------------------------
    function automatic t_status final_check(input logic [4:0] s,
                                            input logic [4:0] halt,
                                            input logic [4:0] rej);
        t_status res;
        if (s == halt) begin
            res = ST_ACCEPT;
        end else if (s == rej) begin
            res = ST_REJECT;
        end else begin
            res = ST_RUN;
        end
        return res;
    endfunction

    logic [7:0]      rstate_ext;
    logic            addr_ok, rstate_ok, mstate_ok, at_edge, do_exec;
    logic [1:0]      mv_norm;
    logic [TA_W-1:0] start_head_sat;
    logic [7:0]      rd_sym;
    logic            x_tape_we;
    logic [TA_W-1:0] x_tape_waddr;
    logic [SYMBOL_BITS-1:0] x_tape_wdata;
    logic            x_rule_we;

    assign do_exec    = ctl.exec && advance;
    assign rstate_ext = 8'(r_req.rule_state);
    assign addr_ok    = 32'(r_req.tape_address) < 32'(TAPE_LEN);
    assign rstate_ok  = 32'(r_req.rule_state) < 32'(NUM_STATES);
    assign mstate_ok  = 32'(r_mstate) < 32'(NUM_STATES);
    // fold the unused move code into stay
    assign mv_norm    = (r_req.move == MV_LEFT || r_req.move == MV_RIGHT)
                        ? r_req.move : MV_STAY;
    assign at_edge    = (rq_move == MV_LEFT && r_head == '0)
                     || (rq_move == MV_RIGHT && r_head == TA_W'(TAPE_LEN - 1));
    assign start_head_sat = (32'(r_start_head) >= 32'(TAPE_LEN))
                            ? TA_W'(TAPE_LEN - 1) : TA_W'(r_start_head);

    always_comb begin
        n_status     = r_status;
        n_mstate     = r_mstate;
        n_head       = r_head;
        rd_sym       = 8'd0;
        x_tape_we    = 1'b0;
        x_tape_waddr = r_head;
        x_tape_wdata = rq_sym;
        x_rule_we    = 1'b0;
        case (t_op'(r_req.operation))
            OP_WRITE_RULE: begin
                x_rule_we = rstate_ok;
            end
            OP_WRITE_CELL: begin
                x_tape_we    = addr_ok;
                x_tape_waddr = TA_W'(r_req.tape_address);
                x_tape_wdata = r_req.tape_symbol[SYMBOL_BITS-1:0];
            end
            OP_START: begin
                n_mstate = r_start_state;
                n_head   = start_head_sat;
                n_status = final_check(r_start_state, r_halt_state, r_reject_state);
            end
            OP_STEP: begin
                // hold everything unless running
                if (r_status == ST_RUN) begin
                    if (!mstate_ok || !rq_valid) begin
                        n_status = ST_NO_RULE;
                    end else if (at_edge) begin
                        n_status = ST_EDGE;
                    end else begin
                        x_tape_we = 1'b1;
                        if (rq_move == MV_LEFT) begin
                            n_head = r_head - TA_W'(1);
                        end else if (rq_move == MV_RIGHT) begin
                            n_head = r_head + TA_W'(1);
                        end
                        n_mstate = rq_next;
                        n_status = final_check(rq_next, r_halt_state, r_reject_state);
                    end
                end
            end
            OP_READ_CELL: begin
                rd_sym = addr_ok ? 8'(tape_q) : 8'(r_blank);
            end
            default: begin
                // unknown operation: report status only
            end
        endcase
    end

    // Write ports: clearing pass after reset, execute phase otherwise
    always_comb begin
        if (ctl.clearing) begin
            tape_we    = 32'(clr_addr) < 32'(TAPE_LEN);
            tape_waddr = clr_addr[TA_W-1:0];
            tape_wdata = SYMBOL_BITS'(BLANK_RESET);
            rule_we    = 32'(clr_addr) < 32'(RULE_DEPTH);
            rule_waddr = clr_addr[RA_W-1:0];
            rule_wdata = '0;
        end else begin
            tape_we    = do_exec && x_tape_we;
            tape_waddr = x_tape_waddr;
            tape_wdata = x_tape_wdata;
            rule_we    = do_exec && x_rule_we;
            rule_waddr = {rstate_ext[SIDX_W-1:0], r_req.rule_symbol[SYMBOL_BITS-1:0]};
            rule_wdata = {1'b1, r_req.next_state,
                          r_req.write_symbol[SYMBOL_BITS-1:0], mv_norm};
        end
    end

    // ------------------------------------------------------------------
    // Machine state and response register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status    <= ST_IDLE;
            r_mstate    <= 5'd0;
            r_head      <= '0;
            o_rsp_valid <= 1'b0;
        end else begin
            if (do_exec) begin
                r_status    <= n_status;
                r_mstate    <= n_mstate;
                r_head      <= n_head;
                o_rsp_valid <= 1'b1;
            end else if (!i_rsp_stall) begin
                o_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_exec) begin
            o_rsp.status        <= n_status;
            o_rsp.current_state <= n_mstate;
            o_rsp.head_position <= 10'(n_head);
            o_rsp.read_symbol   <= rd_sym;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_accept_to_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_fire |=> ctl.rule_rd)
        else $error("accepted request did not move to the rule read phase");

    a_rsp_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp_valid) |-> $past(ctl.exec))
        else $error("response raised outside the execute phase");

    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.clearing |-> (o_req_stall && !o_rsp_valid))
        else $error("request taken or response shown during clearing pass");

    a_exec_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl.exec && !advance) |=> (ctl.exec && $stable(r_req) && $stable(r_head)))
        else $error("execute phase did not hold while the response stalled");

endmodule

`default_nettype wire
